FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/mpct_pkg.sv
// Types and constants of the mouse packet cursor tracker.
package mpct_pkg;

	localparam int LIMIT_W  = 13;
	localparam int CURSOR_W = 12;
	localparam int BTN_W    = 3;

	typedef logic [7:0]          rx_byte_t;
	typedef logic [LIMIT_W-1:0]  limit_t;
	typedef logic [CURSOR_W-1:0] cursor_t;
	typedef logic [BTN_W-1:0]    btn_t;
	typedef logic [1:0]          byte_pos_t;
	typedef logic [0:0]          cfg_idx_t;

	localparam logic     CMD_BYTE = 1'b0;
	localparam logic     CMD_TICK = 1'b1;

	localparam cfg_idx_t REG_SCREEN_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_SCREEN_HEIGHT = 1'b1;

	localparam limit_t   WIDTH_RESET  = 13'd640;
	localparam limit_t   HEIGHT_RESET = 13'd480;

	localparam byte_pos_t POS_FIRST = 2'd0;
	localparam byte_pos_t POS_LAST  = 2'd2;

endpackage

FILE: rtl/core/mpct_if.sv
// Channel interfaces: mouse input, cursor result and configuration write.
interface mpct_in_if;
	import mpct_pkg::*;
	logic     valid;
	logic     ready;
	logic     cmd;
	rx_byte_t rx_byte;
	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mpct_out_if;
	import mpct_pkg::*;
	logic    valid;
	logic    ready;
	cursor_t cursor_x;
	cursor_t cursor_y;
	btn_t    buttons;
	logic    packet_done;
	modport source (output valid, output cursor_x, output cursor_y, output buttons,
		output packet_done, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input buttons,
		input packet_done, output ready);
endinterface

interface mpct_cfg_if;
	import mpct_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	limit_t   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mpct_clamp.sv
// Cursor axis update: add pending motion and clamp into the screen range.
module mpct_clamp #(
	parameter int ACCUM_WIDTH = 16,
	parameter int POS_WIDTH   = 12
) (
	input  logic [POS_WIDTH-1:0]          pos,
	input  logic signed [ACCUM_WIDTH-1:0] delta,
	input  mpct_pkg::limit_t              limit,
	output logic [POS_WIDTH-1:0]          next_pos
);
	import mpct_pkg::*;

	localparam int CW = ACCUM_WIDTH + POS_WIDTH + 2;
	localparam logic signed [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1};
	localparam logic signed [CW-1:0] SPAN =
		{{(CW-POS_WIDTH-1){1'b0}}, 1'b1, {POS_WIDTH{1'b0}}};

	logic signed [CW-1:0] sum;
	logic signed [CW-1:0] lim_ext;
	logic signed [CW-1:0] lim_eff;
	logic signed [CW-1:0] top;

	always_comb begin
		sum = signed'({{(CW-POS_WIDTH){1'b0}}, pos})
			+ signed'({{(CW-ACCUM_WIDTH){delta[ACCUM_WIDTH-1]}}, delta});
		lim_ext = signed'({{(CW-LIMIT_W){1'b0}}, limit});
		if (lim_ext == '0) begin
			lim_eff = ONE;
		end else if (lim_ext > SPAN) begin
			lim_eff = SPAN;
		end else begin
			lim_eff = lim_ext;
		end
		top = lim_eff - ONE;
		if (sum < 0) begin
			next_pos = '0;
		end else if (sum >= lim_eff) begin
			next_pos = top[POS_WIDTH-1:0];
		end else begin
			next_pos = sum[POS_WIDTH-1:0];
		end
	end

endmodule

FILE: rtl/core/mouse_packet_cursor_tracker_unit.sv
// Top level: PS/2 packet decoder, motion accumulator and cursor tracker.
//
//   channel  dir  beat                               accepted when
//   mouse    in   cmd, rx_byte                       mouse.valid && mouse.ready
//   cursor   out  cursor_x, cursor_y, buttons, done  cursor.valid && cursor.ready
//   cfg      in   index, data                        cfg.valid (ready tied high)
//
// One beat per cycle sustained while cursor.ready is high; each input beat passes the input
// register, then the update logic into the result register.
// A stall on cursor holds the result register and a full input register; mouse.ready drops only when both are full.
// Reset: cursor at 320/240 masked to POS_WIDTH, sums and buttons zero, screen 640x480.
module mouse_packet_cursor_tracker_unit #(
	parameter int ACCUM_WIDTH = 16,
	parameter int POS_WIDTH   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	mpct_in_if.sink     mouse,
	mpct_out_if.source  cursor,
	mpct_cfg_if.sink    cfg
);
	import mpct_pkg::*;

	localparam logic signed [ACCUM_WIDTH-1:0] AMAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
	localparam logic signed [ACCUM_WIDTH-1:0] AMIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
	localparam logic [POS_WIDTH-1:0] X_RESET = POS_WIDTH'(320);
	localparam logic [POS_WIDTH-1:0] Y_RESET = POS_WIDTH'(240);

	// input stage
	logic     valid_s1;
	logic     cmd_s1;
	rx_byte_t byte_s1;

	// tracker state
	limit_t                        width_q;
	limit_t                        height_q;
	byte_pos_t                     bpos_q;
	btn_t                          held_btn_q;
	rx_byte_t                      held_dx_q;
	logic signed [ACCUM_WIDTH-1:0] dx_q;
	logic signed [ACCUM_WIDTH-1:0] dy_q;
	btn_t                          btn_q;
	logic [POS_WIDTH-1:0]          x_q;
	logic [POS_WIDTH-1:0]          y_q;

	// result register
	logic    out_valid_q;
	cursor_t out_x_q;
	cursor_t out_y_q;
	btn_t    out_btn_q;
	logic    out_done_q;

	logic                          advance;
	logic                          take;
	logic                          last_byte;
	logic                          move;
	logic signed [ACCUM_WIDTH:0]   dx_wide;
	logic signed [ACCUM_WIDTH:0]   dy_wide;
	logic signed [ACCUM_WIDTH-1:0] dx_sat;
	logic signed [ACCUM_WIDTH-1:0] dy_sat;
	logic [POS_WIDTH-1:0]          x_clamped;
	logic [POS_WIDTH-1:0]          y_clamped;
	logic [POS_WIDTH-1:0]          x_next;
	logic [POS_WIDTH-1:0]          y_next;
	btn_t                          btn_next;

	assign advance      = !out_valid_q || cursor.ready;
	assign mouse.ready  = !valid_s1 || advance;
	assign take         = valid_s1 && advance;
	assign cfg.ready    = 1'b1;

	assign cursor.valid       = out_valid_q;
	assign cursor.cursor_x    = out_x_q;
	assign cursor.cursor_y    = out_y_q;
	assign cursor.buttons     = out_btn_q;
	assign cursor.packet_done = out_done_q;

	assign last_byte = (cmd_s1 == CMD_BYTE) && (bpos_q == POS_LAST);
	assign move      = (cmd_s1 == CMD_TICK) && ((dx_q != '0) || (dy_q != '0));

	always_comb begin
		dx_wide = signed'({dx_q[ACCUM_WIDTH-1], dx_q})
			+ signed'({{(ACCUM_WIDTH-7){held_dx_q[7]}}, held_dx_q});
		dy_wide = signed'({dy_q[ACCUM_WIDTH-1], dy_q})
			- signed'({{(ACCUM_WIDTH-7){byte_s1[7]}}, byte_s1});
		if (dx_wide[ACCUM_WIDTH] != dx_wide[ACCUM_WIDTH-1]) begin
			dx_sat = dx_wide[ACCUM_WIDTH] ? AMIN : AMAX;
		end else begin
			dx_sat = dx_wide[ACCUM_WIDTH-1:0];
		end
		if (dy_wide[ACCUM_WIDTH] != dy_wide[ACCUM_WIDTH-1]) begin
			dy_sat = dy_wide[ACCUM_WIDTH] ? AMIN : AMAX;
		end else begin
			dy_sat = dy_wide[ACCUM_WIDTH-1:0];
		end
		x_next   = move ? x_clamped : x_q;
		y_next   = move ? y_clamped : y_q;
		btn_next = last_byte ? held_btn_q : btn_q;
	end

	mpct_clamp #(
		.ACCUM_WIDTH (ACCUM_WIDTH),
		.POS_WIDTH   (POS_WIDTH)
	) u_clamp_x (
		.pos      (x_q),
		.delta    (dx_q),
		.limit    (width_q),
		.next_pos (x_clamped)
	);

	mpct_clamp #(
		.ACCUM_WIDTH (ACCUM_WIDTH),
		.POS_WIDTH   (POS_WIDTH)
	) u_clamp_y (
		.pos      (y_q),
		.delta    (dy_q),
		.limit    (height_q),
		.next_pos (y_clamped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SCREEN_WIDTH:  width_q  <= cfg.data;
				REG_SCREEN_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mouse.valid && mouse.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mouse.valid && mouse.ready) begin
			cmd_s1  <= mouse.cmd;
			byte_s1 <= mouse.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q <= POS_FIRST;
			dx_q   <= '0;
			dy_q   <= '0;
			btn_q  <= '0;
			x_q    <= X_RESET;
			y_q    <= Y_RESET;
		end else if (take) begin
			x_q   <= x_next;
			y_q   <= y_next;
			btn_q <= btn_next;
			if (cmd_s1 == CMD_BYTE) begin
				if (last_byte) begin
					dx_q   <= dx_sat;
					dy_q   <= dy_sat;
					bpos_q <= POS_FIRST;
				end else begin
					bpos_q <= bpos_q + 2'd1;
				end
			end else if (move) begin
				dx_q <= '0;
				dy_q <= '0;
			end
		end
	end

	// hold the first two bytes of the packet
	always_ff @(posedge clk) begin
		if (take && (cmd_s1 == CMD_BYTE) && !last_byte) begin
			if (bpos_q == POS_FIRST) begin
				held_btn_q <= byte_s1[BTN_W-1:0];
			end else begin
				held_dx_q <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (cursor.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_x_q    <= CURSOR_W'(x_next);
			out_y_q    <= CURSOR_W'(y_next);
			out_btn_q  <= btn_next;
			out_done_q <= last_byte;
		end
	end

endmodule

FILE: rtl/core/mpct_checker.sv
// Port-level checker for the cursor tracker, bound to the top level.
`include "assert_macros.svh"

module mpct_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input mpct_pkg::cursor_t cursor_x,
	input mpct_pkg::cursor_t cursor_y,
	input mpct_pkg::btn_t    buttons,
	input logic              packet_done
);
	import mpct_pkg::*;

	logic    beat;
	logic    seen_q;
	logic    done_q;
	cursor_t x_q;
	cursor_t y_q;
	btn_t    btn_q;

	assign beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			done_q <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			btn_q  <= '0;
		end else if (beat) begin
			seen_q <= 1'b1;
			done_q <= packet_done;
			x_q    <= cursor_x;
			y_q    <= cursor_y;
			btn_q  <= buttons;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(buttons) && $stable(packet_done))
	`ASSERT_NOW(a_done_keeps_cursor, clk, arst_n, beat && seen_q && packet_done, cursor_x == x_q && cursor_y == y_q)
	`ASSERT_NOW(a_buttons_on_done, clk, arst_n, beat && seen_q && !packet_done, buttons == btn_q)
	`ASSERT_NOW(a_done_spacing, clk, arst_n, beat && done_q, !packet_done)

endmodule

bind mouse_packet_cursor_tracker_unit mpct_checker u_mpct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (cursor.valid),
	.out_ready   (cursor.ready),
	.cursor_x    (cursor.cursor_x),
	.cursor_y    (cursor.cursor_y),
	.buttons     (cursor.buttons),
	.packet_done (cursor.packet_done)
);

FILE: sim/mouse_packet_cursor_tracker_unit_test.sv
// Self-checking testbench for the mouse packet cursor tracker: stimulus, predictor and checks.
module mouse_packet_cursor_tracker_unit_test;
	import mpct_pkg::*;

	localparam int ACCUM_W     = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AT     = 200;
	localparam int CALM_FROM   = 1000;
	localparam int CALM_TO     = 1400;

	typedef struct packed {
		logic     cmd;
		rx_byte_t data;
	} mouse_beat_t;

	typedef struct packed {
		cursor_t x;
		cursor_t y;
		btn_t    btn;
		logic    done;
	} cursor_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	mpct_in_if  mouse ();
	mpct_out_if cursor ();
	mpct_cfg_if cfg ();

	mouse_packet_cursor_tracker_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mouse  (mouse),
		.cursor (cursor),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	mouse_beat_t  pending_beats[$];
	cursor_beat_t cursor_expect[$];

	// tracker state mirrored by the predictor
	byte_pos_t trk_pos;
	rx_byte_t  trk_held [2];
	int        trk_dx;
	int        trk_dy;
	btn_t      trk_btn;
	cursor_t   trk_x;
	cursor_t   trk_y;
	limit_t    scr_w;
	limit_t    scr_h;

	int  accepted_beats;
	int  mismatches;
	int  cycles;
	int  hold_left;
	bit  hold_done;
	logic calm;

	assign calm = accepted_beats >= CALM_FROM && accepted_beats < CALM_TO;

	function automatic int sat_sum(int v);
		int hi;
		int lo;
		hi = (1 << (ACCUM_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic cursor_t clamp_move(cursor_t p, int d, limit_t lim);
		int v;
		int l;
		l = int'(lim);
		if (l < 1) l = 1;
		if (l > (1 << CURSOR_W)) l = 1 << CURSOR_W;
		v = int'(p) + d;
		if (v < 0) v = 0;
		if (v >= l) v = l - 1;
		return cursor_t'(v);
	endfunction

	task automatic track_beat(mouse_beat_t m);
		cursor_beat_t e;
		e.done = 1'b0;
		if (m.cmd == CMD_BYTE) begin
			if (trk_pos >= POS_LAST) begin
				trk_dx = sat_sum(trk_dx + int'($signed(trk_held[1])));
				trk_dy = sat_sum(trk_dy - int'($signed(m.data)));
				trk_btn = trk_held[0][BTN_W-1:0];
				trk_pos = POS_FIRST;
				e.done = 1'b1;
			end else begin
				trk_held[trk_pos[0]] = m.data;
				trk_pos = trk_pos + 2'd1;
			end
		end else if (trk_dx != 0 || trk_dy != 0) begin
			trk_x = clamp_move(trk_x, trk_dx, scr_w);
			trk_y = clamp_move(trk_y, trk_dy, scr_h);
			trk_dx = 0;
			trk_dy = 0;
		end
		e.x = trk_x;
		e.y = trk_y;
		e.btn = trk_btn;
		cursor_expect.push_back(e);
	endtask

	// driver: advance the mouse channel whenever its slot is free
	always @(posedge clk) begin
		mouse_beat_t nxt;
		if (arst_n) begin
			if (mouse.valid && mouse.ready) begin
				nxt.cmd = mouse.cmd;
				nxt.data = mouse.rx_byte;
				track_beat(nxt);
				accepted_beats <= accepted_beats + 1;
			end
			if (!mouse.valid || mouse.ready) begin
				if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = pending_beats.pop_front();
					mouse.valid <= 1'b1;
					mouse.cmd <= nxt.cmd;
					mouse.rx_byte <= nxt.data;
				end else begin
					mouse.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps offering
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && accepted_beats >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// monitor: check each cursor beat against the oldest expectation
	always @(posedge clk) begin
		cursor_beat_t e;
		if (arst_n) begin
			if (cursor.valid && cursor.ready) begin
				if (cursor_expect.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected beat: x=%0d y=%0d btn=%0d done=%0d",
							cursor.cursor_x, cursor.cursor_y, cursor.buttons, cursor.packet_done);
				end else begin
					e = cursor_expect.pop_front();
					if (cursor.cursor_x !== e.x || cursor.cursor_y !== e.y ||
						cursor.buttons !== e.btn || cursor.packet_done !== e.done) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("beat error: exp %0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
								e.x, e.y, e.btn, e.done, cursor.cursor_x, cursor.cursor_y,
								cursor.buttons, cursor.packet_done);
					end
				end
			end
			cursor.ready <= hold_left == 0 && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("mouse_packet_cursor_tracker_unit: mismatch");
			$finish;
		end
	end

	task automatic push_byte(rx_byte_t b);
		mouse_beat_t m;
		m.cmd = CMD_BYTE;
		m.data = b;
		pending_beats.push_back(m);
	endtask

	task automatic push_tick();
		mouse_beat_t m;
		m.cmd = CMD_TICK;
		m.data = rx_byte_t'($urandom);
		pending_beats.push_back(m);
	endtask

	task automatic push_packet(rx_byte_t b0, rx_byte_t b1, rx_byte_t b2);
		push_byte(b0);
		push_byte(b1);
		push_byte(b2);
	endtask

	function automatic rx_byte_t motion_byte();
		case ($urandom_range(7))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return rx_byte_t'($urandom);
		endcase
	endfunction

	// drive X and Y sums into saturation at opposite limits, with a few stray bytes mixed in
	task automatic push_drift(bit up);
		rx_byte_t b1;
		rx_byte_t b2;
		repeat (320) begin
			b1 = rx_byte_t'($urandom_range(8'h70, 8'h7F));
			b2 = rx_byte_t'($urandom_range(8'h70, 8'h7F));
			if (!up) b1 = ~b1;
			if (!up) b2 = ~b2;
			if ($urandom_range(15) == 0) b1 = rx_byte_t'($urandom);
			if ($urandom_range(15) == 0) b2 = rx_byte_t'($urandom);
			push_packet(rx_byte_t'($urandom), b1, b2);
		end
		push_tick();
	endtask

	task automatic push_random(int n);
		int k;
		k = 0;
		while (k < n) begin
			case ($urandom_range(19))
				0, 1, 2: begin
					push_tick();
					k = k + 1;
				end
				3, 4: begin
					push_byte(rx_byte_t'($urandom));
					k = k + 1;
				end
				default: begin
					push_packet(rx_byte_t'($urandom), motion_byte(), motion_byte());
					k = k + 3;
					if ($urandom_range(9) < 4) begin
						push_tick();
						k = k + 1;
					end
				end
			endcase
		end
	endtask

	task automatic settle();
		while (pending_beats.size() != 0 || mouse.valid || cursor_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, limit_t val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_w = val;
		else
			scr_h = val;
	endtask

	initial begin
		limit_t w_set [4];
		limit_t h_set [4];
		mouse.valid = 1'b0;
		mouse.cmd = CMD_BYTE;
		mouse.rx_byte = '0;
		cursor.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_SCREEN_WIDTH;
		cfg.data = '0;
		accepted_beats = 0;
		mismatches = 0;
		cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		trk_pos = POS_FIRST;
		trk_held[0] = '0;
		trk_held[1] = '0;
		trk_dx = 0;
		trk_dy = 0;
		trk_btn = '0;
		trk_x = cursor_t'(320);
		trk_y = cursor_t'(240);
		scr_w = WIDTH_RESET;
		scr_h = HEIGHT_RESET;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_tick();
		push_byte(8'h0F);
		push_tick();
		push_byte(8'h7F);
		push_byte(8'h80);
		push_tick();
		push_packet(8'h08, 8'h7F, 8'h80);
		push_packet(8'h08, 8'h7F, 8'h80);
		push_tick();
		push_packet(8'h01, 8'h80, 8'h7F);
		push_tick();
		push_packet(8'hF8, 8'h00, 8'h00);
		push_tick();
		push_packet(8'h02, 8'h7F, 8'h80);
		push_tick();
		settle();

		// shrink the screen under the cursor, one side to zero
		write_reg(REG_SCREEN_WIDTH, 13'd100);
		write_reg(REG_SCREEN_HEIGHT, 13'd0);
		push_tick();
		push_packet(8'h04, 8'h00, 8'h01);
		push_tick();
		push_packet(8'h00, 8'h80, 8'h7F);
		push_tick();
		settle();

		write_reg(REG_SCREEN_WIDTH, 13'd8191);
		write_reg(REG_SCREEN_HEIGHT, 13'd4097);
		push_drift(1'b1);
		settle();

		w_set[0] = 13'd1;
		h_set[0] = 13'd1;
		w_set[1] = 13'd4096;
		h_set[1] = 13'd4096;
		w_set[2] = limit_t'($urandom_range(1, 8191));
		h_set[2] = limit_t'($urandom_range(1, 8191));
		w_set[3] = limit_t'($urandom_range(200, 1000));
		h_set[3] = limit_t'($urandom_range(200, 1000));
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_SCREEN_WIDTH, w_set[p]);
			write_reg(REG_SCREEN_HEIGHT, h_set[p]);
			push_random(75);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && cursor_expect.size() == 0)
			$display("mouse_packet_cursor_tracker_unit: match");
		else
			$display("mouse_packet_cursor_tracker_unit: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mpct_pkg.sv
rtl/core/mpct_if.sv
rtl/core/mpct_clamp.sv
rtl/core/mouse_packet_cursor_tracker_unit.sv
rtl/core/mpct_checker.sv
sim/mouse_packet_cursor_tracker_unit_test.sv
